// File: rtl/gapn_pkg.sv
// Shared constants and types for the gaze axis projection normaliser.
// No dependencies; used by gapn_div and the core top level.
package gapn_pkg;

  // Component and register geometry
  localparam int CB        = 16;
  localparam int NREG      = 8;
  localparam int NREF      = 4;
  localparam int CFG_IDX_W = 4;
  localparam int REG_W     = 3 * CB + 1;
  localparam int PBIT      = 3 * CB;

  // Datapath widths: centroid, differences, cross products, dot products
  localparam int C_W   = CB + 2;
  localparam int D_W   = CB + 1;
  localparam int X_W   = C_W + D_W + 1;
  localparam int P_W   = 2 * X_W;
  localparam int DOT_W = P_W + 2;

  // Restoring divider: one quotient bit per stage
  localparam int QB  = CB + 1;
  localparam int Q_W = CB + 2;
  localparam int R_W = DOT_W + 1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L_INNER = 4'd0,
    REG_L_OUTER = 4'd1,
    REG_L_UP    = 4'd2,
    REG_L_DOWN  = 4'd3,
    REG_R_INNER = 4'd4,
    REG_R_OUTER = 4'd5,
    REG_R_UP    = 4'd6,
    REG_R_DOWN  = 4'd7
  } reg_idx_t;

  // Reference slots within one eye's set
  localparam int REF_INNER = 0;
  localparam int REF_OUTER = 1;
  localparam int REF_UP    = 2;
  localparam int REF_DOWN  = 3;

  // Sideband that travels with each item down the pipeline
  typedef struct packed {
    logic       vld;
    logic       ok;
    logic [3:0] missing;
    logic       degen;
  } tag_t;

endpackage

// File: rtl/gapn_div.sv
// Two-lane pipelined restoring divider with clamp and map to signed Q1.15.
// Depends on gapn_pkg; one quotient bit per register stage.
module gapn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gapn_pkg::tag_t                    tag_in,
  input  logic signed [gapn_pkg::DOT_W-1:0] num_x,
  input  logic signed [gapn_pkg::DOT_W-1:0] span_x,
  input  logic signed [gapn_pkg::DOT_W-1:0] num_y,
  input  logic signed [gapn_pkg::DOT_W-1:0] span_y,
  output gapn_pkg::tag_t                    tag_out,
  output logic signed [gapn_pkg::CB-1:0]    res_x,
  output logic signed [gapn_pkg::CB-1:0]    res_y
);

  localparam int LANES = 2;

  gapn_pkg::tag_t                    tag_r  [gapn_pkg::QB+1];
  logic [gapn_pkg::R_W-1:0]          rem_r  [LANES][gapn_pkg::QB+1];
  logic [gapn_pkg::Q_W-1:0]          q_r    [LANES][gapn_pkg::QB+1];
  logic [gapn_pkg::DOT_W-1:0]        span_r [LANES][gapn_pkg::QB+1];
  logic                              zero_r [LANES][gapn_pkg::QB+1];
  logic signed [gapn_pkg::DOT_W-1:0] num_in  [LANES];
  logic signed [gapn_pkg::DOT_W-1:0] span_in [LANES];
  logic signed [gapn_pkg::CB-1:0]    res_nxt [LANES];
  gapn_pkg::tag_t                    tag_o_r;
  logic signed [gapn_pkg::CB-1:0]    res_r  [LANES];

  assign num_in[0]  = num_x;
  assign span_in[0] = span_x;
  assign num_in[1]  = num_y;
  assign span_in[1] = span_y;

  // Sideband delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= gapn_pkg::QB; s++) tag_r[s] <= '0;
      tag_o_r <= '0;
    end else begin
      tag_r[0] <= tag_in;
      for (int s = 1; s <= gapn_pkg::QB; s++) tag_r[s] <= tag_r[s-1];
      tag_o_r <= tag_r[gapn_pkg::QB];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [gapn_pkg::DOT_W-1:0] numc;
    logic                       zspan;

    // Prep: empty span check, clamp below at 0, top quotient bit
    always_comb begin
      zspan = span_in[l][gapn_pkg::DOT_W-1] || (span_in[l] == '0);
      numc  = num_in[l][gapn_pkg::DOT_W-1] ? '0 : num_in[l];
    end

    always_ff @(posedge clk) begin
      zero_r[l][0] <= zspan;
      span_r[l][0] <= span_in[l];
      if (numc >= span_in[l]) begin
        q_r[l][0]   <= gapn_pkg::Q_W'(1);
        rem_r[l][0] <= '0;
      end else begin
        q_r[l][0]   <= '0;
        rem_r[l][0] <= gapn_pkg::R_W'(numc);
      end
    end

    // One restoring step per stage
    for (genvar s = 1; s <= gapn_pkg::QB; s++) begin : g_stage
      logic [gapn_pkg::R_W-1:0] sh;
      logic                     ge;
      always_comb begin
        sh = {rem_r[l][s-1][gapn_pkg::R_W-2:0], 1'b0};
        ge = sh >= {1'b0, span_r[l][s-1]};
      end
      always_ff @(posedge clk) begin
        zero_r[l][s] <= zero_r[l][s-1];
        span_r[l][s] <= span_r[l][s-1];
        rem_r[l][s]  <= ge ? sh - {1'b0, span_r[l][s-1]} : sh;
        q_r[l][s]    <= {q_r[l][s-1][gapn_pkg::Q_W-2:0], ge};
      end
    end

    // Round half up, recentre and saturate; zero when the item is not ok or the span is empty
    logic [gapn_pkg::Q_W:0]        qp;
    logic signed [gapn_pkg::Q_W:0] v;
    always_comb begin
      qp = {1'b0, q_r[l][gapn_pkg::QB]} + (gapn_pkg::Q_W+1)'(1);
      v  = $signed({1'b0, qp[gapn_pkg::Q_W:1]})
           - $signed((gapn_pkg::Q_W+1)'(1) << (gapn_pkg::CB-1));
      if (!tag_r[gapn_pkg::QB].ok || zero_r[l][gapn_pkg::QB]) begin
        res_nxt[l] = '0;
      end else if (v > $signed((gapn_pkg::Q_W+1)'((1 << (gapn_pkg::CB-1)) - 1))) begin
        res_nxt[l] = gapn_pkg::CB'((1 << (gapn_pkg::CB-1)) - 1);
      end else begin
        res_nxt[l] = v[gapn_pkg::CB-1:0];
      end
    end

    always_ff @(posedge clk) begin
      res_r[l] <= res_nxt[l];
    end
  end

  assign tag_out = tag_o_r;
  assign res_x   = res_r[0];
  assign res_y   = res_r[1];

endmodule

// File: rtl/gaze_axis_projection_normalizer_core.sv
// Gaze axis projection normaliser: reference registers, frame maths pipeline
// and the gapn_div divider. Depends on gapn_pkg and gapn_div.
// One item per cycle sustained.
// Depth is set by four vector-maths stages, a divider prep stage, seventeen
// one-bit divider stages and the output register. busy stays low.
// Synchronous active-low reset clears the reference registers and valid bits.
module gaze_axis_projection_normalizer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_eye_side,
  input  logic signed [gapn_pkg::CB-1:0]     in_gaze_x,
  input  logic signed [gapn_pkg::CB-1:0]     in_gaze_y,
  input  logic signed [gapn_pkg::CB-1:0]     in_gaze_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gapn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gapn_pkg::REG_W-1:0]         cfg_data,
  output logic                               out_strobe,
  output logic                               out_result_valid,
  output logic signed [gapn_pkg::CB-1:0]     out_norm_x,
  output logic signed [gapn_pkg::CB-1:0]     out_norm_y,
  output logic [3:0]                         out_missing_mask,
  output logic                               out_degenerate
);

  localparam int CB  = gapn_pkg::CB;
  localparam int C_W = gapn_pkg::C_W;
  localparam int D_W = gapn_pkg::D_W;
  localparam int X_W = gapn_pkg::X_W;
  localparam int P_W = gapn_pkg::P_W;
  localparam int DW  = gapn_pkg::DOT_W;

  logic in_acc;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  // Reference registers
  logic [gapn_pkg::REG_W-1:0] ref_r [gapn_pkg::NREG];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gapn_pkg::NREG; i++) ref_r[i] <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index <= gapn_pkg::REG_R_DOWN)) begin
      ref_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Stage 0: select eye set, centroid and difference vectors
  logic [gapn_pkg::REG_W-1:0] sel    [gapn_pkg::NREF];
  logic signed [CB-1:0]       v      [gapn_pkg::NREF][3];
  logic signed [CB-1:0]       g      [3];
  logic [3:0]                 miss_nxt;
  logic signed [C_W-1:0]      c_nxt  [3];
  logic signed [D_W-1:0]      r_nxt  [3];
  logic signed [D_W-1:0]      w1_nxt [3];
  logic signed [D_W-1:0]      w2_nxt [3];
  logic signed [D_W-1:0]      u_nxt  [3];

  assign g[0] = in_gaze_x;
  assign g[1] = in_gaze_y;
  assign g[2] = in_gaze_z;

  always_comb begin
    for (int k = 0; k < gapn_pkg::NREF; k++) begin
      sel[k]      = in_eye_side ? ref_r[gapn_pkg::NREF + k] : ref_r[k];
      miss_nxt[k] = !sel[k][gapn_pkg::PBIT];
      for (int j = 0; j < 3; j++) v[k][j] = $signed(sel[k][j*CB +: CB]);
    end
    for (int j = 0; j < 3; j++) begin
      c_nxt[j]  = C_W'(v[gapn_pkg::REF_INNER][j]) + C_W'(v[gapn_pkg::REF_OUTER][j])
                + C_W'(v[gapn_pkg::REF_UP][j]) + C_W'(v[gapn_pkg::REF_DOWN][j]);
      r_nxt[j]  = D_W'(v[gapn_pkg::REF_INNER][j]) - D_W'(v[gapn_pkg::REF_OUTER][j]);
      w1_nxt[j] = D_W'(g[j]) - D_W'(v[gapn_pkg::REF_OUTER][j]);
      w2_nxt[j] = D_W'(g[j]) - D_W'(v[gapn_pkg::REF_DOWN][j]);
      u_nxt[j]  = D_W'(v[gapn_pkg::REF_UP][j]) - D_W'(v[gapn_pkg::REF_DOWN][j]);
    end
  end

  logic                  vld0_r;
  logic [3:0]            miss0_r;
  logic signed [C_W-1:0] c0_r  [3];
  logic signed [D_W-1:0] r0_r  [3];
  logic signed [D_W-1:0] w10_r [3];
  logic signed [D_W-1:0] w20_r [3];
  logic signed [D_W-1:0] u0_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_acc;
    end
    miss0_r <= miss_nxt;
    c0_r    <= c_nxt;
    r0_r    <= r_nxt;
    w10_r   <= w1_nxt;
    w20_r   <= w2_nxt;
    u0_r    <= u_nxt;
  end

  // Stage 1: axis a = c x r and b = c x (g - outer)
  logic signed [X_W-1:0] a_nxt [3];
  logic signed [X_W-1:0] b_nxt [3];
  logic                  cz_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_nxt[j] = X_W'(c0_r[(j+1)%3]) * X_W'(r0_r[(j+2)%3])
               - X_W'(c0_r[(j+2)%3]) * X_W'(r0_r[(j+1)%3]);
      b_nxt[j] = X_W'(c0_r[(j+1)%3]) * X_W'(w10_r[(j+2)%3])
               - X_W'(c0_r[(j+2)%3]) * X_W'(w10_r[(j+1)%3]);
    end
    cz_nxt = (c0_r[0] == '0) && (c0_r[1] == '0) && (c0_r[2] == '0);
  end

  logic                  vld1_r;
  logic [3:0]            miss1_r;
  logic                  cz1_r;
  logic signed [X_W-1:0] a1_r  [3];
  logic signed [X_W-1:0] b1_r  [3];
  logic signed [D_W-1:0] w21_r [3];
  logic signed [D_W-1:0] u1_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld0_r;
    end
    miss1_r <= miss0_r;
    cz1_r   <= cz_nxt;
    a1_r    <= a_nxt;
    b1_r    <= b_nxt;
    w21_r   <= w20_r;
    u1_r    <= u0_r;
  end

  // Stage 2: element products for the four dot products, degeneracy check
  logic signed [P_W-1:0] pab_nxt [3];
  logic signed [P_W-1:0] paa_nxt [3];
  logic signed [P_W-1:0] pwa_nxt [3];
  logic signed [P_W-1:0] pua_nxt [3];
  logic                  dg_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pab_nxt[j] = P_W'(a1_r[j]) * P_W'(b1_r[j]);
      paa_nxt[j] = P_W'(a1_r[j]) * P_W'(a1_r[j]);
      pwa_nxt[j] = P_W'(w21_r[j]) * P_W'(a1_r[j]);
      pua_nxt[j] = P_W'(u1_r[j]) * P_W'(a1_r[j]);
    end
    dg_nxt = cz1_r || ((a1_r[0] == '0) && (a1_r[1] == '0) && (a1_r[2] == '0));
  end

  logic                  vld2_r;
  logic [3:0]            miss2_r;
  logic                  dg2_r;
  logic signed [P_W-1:0] pab_r [3];
  logic signed [P_W-1:0] paa_r [3];
  logic signed [P_W-1:0] pwa_r [3];
  logic signed [P_W-1:0] pua_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    miss2_r <= miss1_r;
    dg2_r   <= dg_nxt;
    pab_r   <= pab_nxt;
    paa_r   <= paa_nxt;
    pwa_r   <= pwa_nxt;
    pua_r   <= pua_nxt;
  end

  // Stage 3: sum products into numerators and spans, settle status
  gapn_pkg::tag_t       tag_nxt;
  logic signed [DW-1:0] nx_nxt, sx_nxt, ny_nxt, sy_nxt;

  always_comb begin
    nx_nxt = DW'(pab_r[0]) + DW'(pab_r[1]) + DW'(pab_r[2]);
    sx_nxt = DW'(paa_r[0]) + DW'(paa_r[1]) + DW'(paa_r[2]);
    ny_nxt = DW'(pwa_r[0]) + DW'(pwa_r[1]) + DW'(pwa_r[2]);
    sy_nxt = DW'(pua_r[0]) + DW'(pua_r[1]) + DW'(pua_r[2]);
    tag_nxt.vld     = vld2_r;
    tag_nxt.missing = miss2_r;
    tag_nxt.degen   = (miss2_r == '0) && dg2_r;
    tag_nxt.ok      = (miss2_r == '0) && !dg2_r;
  end

  gapn_pkg::tag_t       tag3_r;
  logic signed [DW-1:0] nx3_r, sx3_r, ny3_r, sy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
    end else begin
      tag3_r <= tag_nxt;
    end
    nx3_r <= nx_nxt;
    sx3_r <= sx_nxt;
    ny3_r <= ny_nxt;
    sy3_r <= sy_nxt;
  end

  // Divide, clamp and map both coordinates
  gapn_pkg::tag_t tag_o;
  logic signed [CB-1:0] res_x, res_y;

  gapn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag3_r),
    .num_x   (nx3_r),
    .span_x  (sx3_r),
    .num_y   (ny3_r),
    .span_y  (sy3_r),
    .tag_out (tag_o),
    .res_x   (res_x),
    .res_y   (res_y)
  );

  assign out_strobe       = tag_o.vld;
  assign out_result_valid = tag_o.vld && tag_o.ok;
  assign out_norm_x       = res_x;
  assign out_norm_y       = res_y;
  assign out_missing_mask = tag_o.missing;
  assign out_degenerate   = tag_o.degen;

`ifndef ASSERT_OFF
  // A valid result never carries a missing reference or a degenerate frame
  a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_result_valid |-> (out_missing_mask == '0) && !out_degenerate)
    else $error("valid result with missing or degenerate status");

  // Invalid results carry zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result_valid) |-> (out_norm_x == '0) && (out_norm_y == '0))
    else $error("invalid result with non-zero coordinates");

  // Degenerate only reported with a full reference set
  a_degen_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_degenerate |-> (out_missing_mask == '0) && !out_result_valid)
    else $error("degenerate flag with missing references");
`endif

endmodule

// File: bench/tb_gaze_axis_projection_normalizer_core.sv
// Self-checking bench for gaze_axis_projection_normalizer_core: predicts each
// projected gaze item and checks it against the block. Depends on gapn_pkg.
module tb_gaze_axis_projection_normalizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = gapn_pkg::CB;
  localparam int REG_W     = gapn_pkg::REG_W;
  localparam int NREG      = gapn_pkg::NREG;
  localparam int NREF      = gapn_pkg::NREF;
  localparam int PBIT      = gapn_pkg::PBIT;
  localparam int CFG_IDX_W = gapn_pkg::CFG_IDX_W;
  localparam int REF_INNER = gapn_pkg::REF_INNER;
  localparam int REF_OUTER = gapn_pkg::REF_OUTER;
  localparam int REF_UP    = gapn_pkg::REF_UP;
  localparam int REF_DOWN  = gapn_pkg::REF_DOWN;

  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic signed [127:0] wide_t;
  typedef longint vec3_t [3];

  typedef struct {
    logic                 side;
    logic signed [CB-1:0] gx, gy, gz;
  } gaze_item_t;

  typedef struct {
    logic                 valid;
    logic signed [CB-1:0] nx, ny;
    logic [3:0]           missing;
    logic                 degen;
  } frame_pos_t;

  logic clk = 0, rst_n = 0;
  logic start = 0, busy;
  logic in_eye_side = 0;
  logic signed [CB-1:0] in_gaze_x = '0, in_gaze_y = '0, in_gaze_z = '0;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic out_strobe, out_result_valid, out_degenerate;
  logic signed [CB-1:0] out_norm_x, out_norm_y;
  logic [3:0] out_missing_mask;

  gaze_axis_projection_normalizer_core dut (.*);

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  gaze_item_t pending_gaze [$];
  frame_pos_t expected_pos [$];
  logic [REG_W-1:0] cal_mirror [NREG];
  int n_issued = 0, n_taken = 0, errors = 0, cycles = 0;
  bit idle_on = 1;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // exact-integer frame maths
  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic wide_t dot3(vec3_t a, vec3_t b);
    return wide_t'(a[0]) * wide_t'(b[0]) + wide_t'(a[1]) * wide_t'(b[1])
         + wide_t'(a[2]) * wide_t'(b[2]);
  endfunction

  // clamp num into [0, span] and map the ratio onto the signed output range
  function automatic logic signed [CB-1:0] span_ratio(wide_t num, wide_t span);
    wide_t rem;
    longint q, v;
    if (span <= 0) return '0;
    if (num < 0) num = 0;
    if (num >= span) begin
      q = 1; rem = 0;
    end else begin
      q = 0; rem = num;
    end
    for (int i = 0; i < CB + 1; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= span) begin
        rem = rem - span;
        q = q | 1;
      end
    end
    v = ((q + 1) >>> 1) - (64'sd1 <<< (CB - 1));
    if (v > (64'sd1 <<< (CB - 1)) - 1) v = (64'sd1 <<< (CB - 1)) - 1;
    return v[CB-1:0];
  endfunction

  function automatic frame_pos_t project_gaze(gaze_item_t it);
    frame_pos_t e;
    longint v [4][3];
    vec3_t g, c, r, a, w, b, u;
    logic [REG_W-1:0] rv;
    e = '{default: '0};
    for (int k = 0; k < NREF; k++) begin
      rv = cal_mirror[it.side * NREF + k];
      if (!rv[PBIT]) e.missing[k] = 1'b1;
      for (int j = 0; j < 3; j++) v[k][j] = longint'($signed(rv[j*CB +: CB]));
    end
    if (e.missing != 0) return e;
    g[0] = longint'(it.gx); g[1] = longint'(it.gy); g[2] = longint'(it.gz);
    for (int j = 0; j < 3; j++) begin
      c[j] = v[REF_INNER][j] + v[REF_OUTER][j] + v[REF_UP][j] + v[REF_DOWN][j];
      r[j] = v[REF_INNER][j] - v[REF_OUTER][j];
    end
    a = cross3(c, r);
    if ((c[0] == 0 && c[1] == 0 && c[2] == 0) || (a[0] == 0 && a[1] == 0 && a[2] == 0)) begin
      e.degen = 1'b1;
      return e;
    end
    for (int j = 0; j < 3; j++) w[j] = g[j] - v[REF_OUTER][j];
    b = cross3(c, w);
    e.nx = span_ratio(dot3(a, b), dot3(a, a));
    for (int j = 0; j < 3; j++) begin
      w[j] = g[j] - v[REF_DOWN][j];
      u[j] = v[REF_UP][j] - v[REF_DOWN][j];
    end
    e.ny = span_ratio(dot3(w, a), dot3(u, a));
    e.valid = 1'b1;
    return e;
  endfunction

  // acceptance of items and register writes, result checking
  always @(posedge clk) begin
    gaze_item_t it;
    frame_pos_t e;
    cycles <= cycles + 1;
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) cal_mirror[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NREG) cal_mirror[cfg_index[2:0]] <= cfg_data;
      if (start && !busy) begin
        it.side = in_eye_side; it.gx = in_gaze_x; it.gy = in_gaze_y; it.gz = in_gaze_z;
        expected_pos = {expected_pos, project_gaze(it)};
        n_taken <= n_taken + 1;
      end
      if (out_strobe) begin
        if (expected_pos.size() == 0) begin
          report("unexpected item", 32'd0, 32'd0);
        end else begin
          e = expected_pos.pop_front();
          if (out_result_valid !== e.valid)
            report("result_valid", 32'(out_result_valid), 32'(e.valid));
          if (out_norm_x !== e.nx) report("norm_x", 32'(out_norm_x), 32'(e.nx));
          if (out_norm_y !== e.ny) report("norm_y", 32'(out_norm_y), 32'(e.ny));
          if (out_missing_mask !== e.missing)
            report("missing_mask", 32'(out_missing_mask), 32'(e.missing));
          if (out_degenerate !== e.degen)
            report("degenerate", 32'(out_degenerate), 32'(e.degen));
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // item driver: hold until taken, random idle gaps
  always @(negedge clk) begin
    gaze_item_t it;
    if (rst_n && (!start || n_taken == n_issued)) begin
      if (pending_gaze.size() != 0 && !(idle_on && $urandom_range(99) < 37)) begin
        it = pending_gaze.pop_front();
        in_eye_side <= it.side;
        in_gaze_x <= it.gx; in_gaze_y <= it.gy; in_gaze_z <= it.gz;
        start <= 1'b1;
        n_issued <= n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic [REG_W-1:0] pack_ref(int x, int y, int z, bit present);
    logic [CB-1:0] xs, ys, zs;
    xs = CB'(x); ys = CB'(y); zs = CB'(z);
    return {present, zs, ys, xs};
  endfunction

  function automatic int clip16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic add_gaze(bit side, int x, int y, int z);
    gaze_item_t it;
    it.side = side; it.gx = CB'(clip16(x)); it.gy = CB'(clip16(y)); it.gz = CB'(clip16(z));
    pending_gaze = {pending_gaze, it};
  endtask

  // wait until every item is out and the pipeline has emptied
  task automatic drain();
    while (pending_gaze.size() != 0 || start || expected_pos.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_side(bit side, logic [REG_W-1:0] inn, logic [REG_W-1:0] outr,
                           logic [REG_W-1:0] up, logic [REG_W-1:0] dn);
    write_reg(gapn_pkg::reg_idx_t'(side * NREF + REF_INNER), inn);
    write_reg(gapn_pkg::reg_idx_t'(side * NREF + REF_OUTER), outr);
    write_reg(gapn_pkg::reg_idx_t'(side * NREF + REF_UP), up);
    write_reg(gapn_pkg::reg_idx_t'(side * NREF + REF_DOWN), dn);
  endtask

  // plausible calibration frame with jitter; mode picks odd variants
  task automatic load_frame(bit side, int mode);
    int h, v, z;
    bit [3:0] pres;
    h = $urandom_range(12000, 500);
    v = $urandom_range(12000, 500);
    z = $urandom_range(31000, 12000);
    pres = 4'hf;
    if (mode == 1) pres = 4'($urandom_range(14));
    if (mode == 2) begin
      load_side(side, {1'b1, 48'($urandom) << 16 ^ 48'($urandom)},
                {1'b1, 48'($urandom) << 16 ^ 48'($urandom)},
                {1'b1, 48'($urandom) << 16 ^ 48'($urandom)},
                {1'b1, 48'($urandom) << 16 ^ 48'($urandom)});
    end else begin
      load_side(side,
        pack_ref(h + $urandom_range(400) - 200, $urandom_range(400) - 200, z, pres[0]),
        pack_ref(-h + $urandom_range(400) - 200, $urandom_range(400) - 200, z, pres[1]),
        pack_ref($urandom_range(400) - 200, v + $urandom_range(400) - 200, z, pres[2]),
        pack_ref($urandom_range(400) - 200, -v + $urandom_range(400) - 200, z, pres[3]));
    end
  endtask

  initial begin
    int sd;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset state: every reference absent on both eyes
    add_gaze(0, 0, 0, 0);
    add_gaze(1, 32767, -32768, 32767);
    add_gaze(0, -32768, 32767, -32768);
    drain();

    // stray indexes beyond the register file are ignored
    write_reg(CFG_IDX_W'(NREG), {REG_W{1'b1}});
    write_reg(CFG_IDX_W'(NREG + 7), {REG_W{1'b1}});

    // tidy frames on both eyes, gaze at the extremes and inside
    load_side(0, pack_ref(8000, 0, 24000, 1), pack_ref(-8000, 0, 24000, 1),
              pack_ref(0, 8000, 24000, 1), pack_ref(0, -8000, 24000, 1));
    load_side(1, pack_ref(6000, 300, 26000, 1), pack_ref(-7000, -200, 25000, 1),
              pack_ref(100, 9000, 25500, 1), pack_ref(-100, -6000, 25000, 1));
    end_writes();
    for (int s = 0; s < 2; s++) begin
      add_gaze(s, 0, 0, 24000);
      add_gaze(s, 8000, 8000, 24000);
      add_gaze(s, -8000, -8000, 24000);
      add_gaze(s, 32767, 32767, 32767);
      add_gaze(s, -32768, -32768, -32768);
      add_gaze(s, 3000, -2000, 24500);
    end
    drain();

    // empty vertical span, then an inner equal to outer, then a zero centroid
    load_side(0, pack_ref(8000, 0, 24000, 1), pack_ref(-8000, 0, 24000, 1),
              pack_ref(0, 500, 24000, 1), pack_ref(0, 500, 24000, 1));
    load_side(1, pack_ref(4000, 0, 24000, 1), pack_ref(4000, 0, 24000, 1),
              pack_ref(0, 8000, 24000, 1), pack_ref(0, -8000, 24000, 1));
    end_writes();
    add_gaze(0, 1000, 2000, 24000);
    add_gaze(1, 1000, 2000, 24000);
    drain();
    load_side(1, pack_ref(8000, 0, 0, 1), pack_ref(-8000, 0, 0, 1),
              pack_ref(0, 8000, 0, 1), pack_ref(0, -8000, 0, 1));
    write_reg(gapn_pkg::REG_L_UP, pack_ref(0, 8000, 24000, 0));
    end_writes();
    add_gaze(1, 100, 100, 100);
    add_gaze(0, 100, 100, 100);
    drain();

    // register extremes: all ones, and full-scale components
    load_side(0, {REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}});
    load_side(1, pack_ref(32767, -32768, 32767, 1), pack_ref(-32768, 32767, -32768, 1),
              pack_ref(32767, 32767, 32767, 1), pack_ref(-32768, -32768, 32767, 1));
    end_writes();
    add_gaze(0, 5, 5, 5);
    add_gaze(1, 32767, -32768, 0);
    drain();

    // random phases: mostly tidy frames with gaze near them, some noise
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph != 3);
      for (int s = 0; s < 2; s++) begin
        sd = $urandom_range(99);
        load_frame(s, sd < 70 ? 0 : (sd < 85 ? 1 : 2));
      end
      end_writes();
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(99) < 75)
          add_gaze($urandom_range(1), $urandom_range(30000) - 15000,
                   $urandom_range(30000) - 15000, $urandom_range(32767, 10000));
        else
          add_gaze($urandom_range(1), $urandom_range(65535) - 32768,
                   $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
      end
      drain();
    end

    // back to the reset values everywhere
    load_side(0, '0, '0, '0, '0);
    load_side(1, '0, '0, '0, '0);
    end_writes();
    add_gaze(0, 1, 1, 1);
    add_gaze(1, 1, 1, 1);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
